// File: hw/rtl/pat_pkg.sv
package pat_pkg;

    localparam int SLOTS = 16;
    localparam int SLOT_W = 4;

    typedef enum logic [1:0] {
        FUNC_ARM    = 2'd0,
        FUNC_CANCEL = 2'd1,
        FUNC_QUERY  = 2'd2,
        FUNC_EXPIRE = 2'd3
    } func_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [3:0]  slot;
        logic [63:0] now_time;
        logic [63:0] delay;
        logic [63:0] reload;
        logic [15:0] owner;
    } req_t;

    typedef struct packed {
        logic        kind;
        logic [3:0]  fired_slot;
        logic [15:0] fired_owner;
        logic [63:0] time_left;
        logic [63:0] period_out;
        logic        last;
    } rsp_t;

    typedef struct packed {
        logic [63:0] deadline;
        logic [63:0] period;
        logic [15:0] owner_tag;
    } entry_t;

endpackage

// File: hw/rtl/periodic_alarm_timer_bank_top.sv
// Bank of 16 alarm slots. A request is taken when start is high and busy is
// low; every result appears for one cycle with result_valid and cannot be
// stalled. Slot entries live in a synchronous memory (one read, one write per
// cycle); armed flags are flip-flops. Arm, cancel and query go through a
// memory read (ST_RD) and then a reply (ST_OP). An expire scan first loads
// every deadline from the memory into a due list, then handles each fired
// slot in turn: a 16-way minimum search, a memory read, then writeback and
// event output.
module periodic_alarm_timer_bank_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  pat_pkg::req_t req,
    output logic          busy,
    output logic          result_valid,
    output pat_pkg::rsp_t result
);
    import pat_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_RD     = 7'b0000010,
        ST_OP     = 7'b0000100,
        ST_LOAD   = 7'b0001000,
        ST_PICK   = 7'b0010000,
        ST_FRD    = 7'b0100000,
        ST_FIRE   = 7'b1000000
    } state_t;

    entry_t mem [SLOTS];
    entry_t rd_data;
    logic   mem_we;
    logic [SLOT_W-1:0] mem_waddr, mem_raddr;
    entry_t mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data <= mem[mem_raddr];
    end

    state_t state_reg, state_next;
    req_t   req_reg;
    logic [SLOTS-1:0] armed_reg, armed_next;
    logic [SLOTS-1:0] due_reg, due_next;
    logic [63:0] dl_reg [SLOTS];
    logic [SLOT_W:0] cnt_reg, cnt_next;
    logic [SLOT_W-1:0] best_reg, best_next;
    logic [SLOT_W:0] fired_reg, fired_next;
    logic load_v_reg;
    logic [SLOT_W-1:0] load_a_reg;

    logic [63:0] now, left;
    logic        found;
    logic [SLOT_W-1:0] bidx;
    logic        more;

    logic              t_v [2*SLOTS-1];
    logic [SLOT_W-1:0] t_i [2*SLOTS-1];
    logic [63:0]       t_d [2*SLOTS-1];

    assign now = req_reg.now_time;
    assign left = (rd_data.deadline > now) ? rd_data.deadline - now : 64'd0;

    // comparison tree, lower slot wins on equal deadlines
    always_comb
    begin
        for (int j = 0; j < SLOTS; j++)
        begin
            t_v[SLOTS-1+j] = due_reg[j];
            t_i[SLOTS-1+j] = SLOT_W'(j);
            t_d[SLOTS-1+j] = dl_reg[j];
        end
        for (int k = SLOTS-2; k >= 0; k--)
        begin
            if (t_v[2*k+1] && (!t_v[2*k+2] || t_d[2*k+1] <= t_d[2*k+2]))
            begin
                t_v[k] = t_v[2*k+1];
                t_i[k] = t_i[2*k+1];
                t_d[k] = t_d[2*k+1];
            end
            else
            begin
                t_v[k] = t_v[2*k+2];
                t_i[k] = t_i[2*k+2];
                t_d[k] = t_d[2*k+2];
            end
        end
        found = t_v[0];
        bidx = t_i[0];
    end

    always_comb
    begin
        more = 1'b0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (due_reg[i] && SLOT_W'(i) != best_reg)
            begin
                more = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_v_reg)
        begin
            dl_reg[load_a_reg] <= rd_data.deadline;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        armed_next = armed_reg;
        due_next = due_reg;
        cnt_next = cnt_reg;
        best_next = best_reg;
        fired_next = fired_reg;
        mem_we = 1'b0;
        mem_waddr = req_reg.slot;
        mem_wdata = rd_data;
        mem_raddr = req_reg.slot;
        result_valid = 1'b0;
        result = '0;
        case (state_reg)
            ST_IDLE:
            begin
                mem_raddr = req.slot;
                if (start)
                begin
                    if (func_t'(req.func) == FUNC_EXPIRE)
                    begin
                        state_next = ST_LOAD;
                        cnt_next = '0;
                        fired_next = '0;
                        due_next = '0;
                    end
                    else
                    begin
                        state_next = ST_RD;
                    end
                end
            end
            ST_RD:
            begin
                state_next = ST_OP;
            end
            ST_OP:
            begin
                result_valid = 1'b1;
                result.fired_slot = req_reg.slot;
                result.last = 1'b1;
                if (armed_reg[req_reg.slot])
                begin
                    result.time_left = left;
                end
                case (func_t'(req_reg.func))
                    FUNC_ARM:
                    begin
                        mem_we = 1'b1;
                        mem_wdata.deadline = now + req_reg.delay;
                        mem_wdata.period = req_reg.reload;
                        mem_wdata.owner_tag = req_reg.owner;
                        armed_next[req_reg.slot] = 1'b1;
                    end
                    FUNC_CANCEL:
                    begin
                        if (armed_reg[req_reg.slot])
                        begin
                            mem_we = 1'b1;
                            mem_wdata.period = '0;
                            armed_next[req_reg.slot] = 1'b0;
                        end
                    end
                    default:
                    begin
                        // a disarmed slot always reports a zero interval
                        result.period_out = armed_reg[req_reg.slot] ? rd_data.period : 64'd0;
                    end
                endcase
                state_next = ST_IDLE;
            end
            ST_LOAD:
            begin
                mem_raddr = cnt_reg[SLOT_W-1:0];
                if (load_v_reg)
                begin
                    due_next[load_a_reg] = armed_reg[load_a_reg] &&
                        !(rd_data.deadline > now);
                end
                if (cnt_reg == (SLOT_W+1)'(SLOTS))
                begin
                    state_next = ST_PICK;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_PICK:
            begin
                best_next = bidx;
                mem_raddr = bidx;
                state_next = found ? ST_FRD : ST_IDLE;
            end
            ST_FRD:
            begin
                mem_raddr = best_reg;
                state_next = ST_FIRE;
            end
            ST_FIRE:
            begin
                result_valid = 1'b1;
                result.kind = 1'b1;
                result.fired_slot = best_reg;
                result.fired_owner = rd_data.owner_tag;
                due_next[best_reg] = 1'b0;
                fired_next = fired_reg + 1'b1;
                if (rd_data.period != 64'd0)
                begin
                    mem_we = 1'b1;
                    mem_waddr = best_reg;
                    mem_wdata.deadline = now + rd_data.period;
                end
                else
                begin
                    armed_next[best_reg] = 1'b0;
                end
                if (!more || fired_reg == (SLOT_W+1)'(SLOTS - 1))
                begin
                    result.last = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_PICK;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            armed_reg <= '0;
            due_reg <= '0;
            cnt_reg <= '0;
            best_reg <= '0;
            fired_reg <= '0;
            load_v_reg <= 1'b0;
            load_a_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            armed_reg <= armed_next;
            due_reg <= due_next;
            cnt_reg <= cnt_next;
            best_reg <= best_next;
            fired_reg <= fired_next;
            load_v_reg <= (state_reg == ST_LOAD) && (cnt_reg != (SLOT_W+1)'(SLOTS));
            load_a_reg <= cnt_reg[SLOT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            req_reg <= req;
        end
    end

endmodule
